// File: sv/trsi_pkg.sv
// Package for two_region_sorted_insert: item and result types, codes, sizes.
// No dependencies.
package trsi_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned KEY_W  = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_READ
  } state_e;

  typedef struct packed {
    logic [1:0]              mode;
    logic                    group;
    logic signed [KEY_W-1:0] key;
    logic [ADDR_W-1:0]       index;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] read_key;
    logic [CNT_W-1:0]        front_count;
    logic [CNT_W-1:0]        back_count;
    logic [1:0]              status;
  } rsp_t;

endpackage

// File: sv/two_region_sorted_insert.sv
// Top level: two sorted key regions sharing one key store.
// Depends on trsi_pkg and trsi_ram.
//
// An item is taken when start_i is high and busy_o low; its result shows on
// rsp_o for one cycle with done_o high and cannot be held off. Clear, unused
// mode, full-store and out-of-range items answer in the next cycle without
// raising busy_o. A read waits in S_READ for its one RAM read. An insert walks
// its region through the single RAM, one entry moved per cycle with the read
// of the next neighbor overlapped with the write-back, then places the new key.
module two_region_sorted_insert (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  trsi_pkg::req_t       req_i,
  output logic                 busy_o,
  output logic                 done_o,
  output trsi_pkg::rsp_t       rsp_o,
  input  logic                 cfg_we_i,
  input  logic [trsi_pkg::CNT_W-1:0] cfg_wdata_i
);
  import trsi_pkg::*;

  state_e                   state_q, state_d;
  logic [ADDR_W-1:0]        pos_q, pos_d;
  logic                     grp_q, grp_d;
  logic signed [KEY_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]         front_fill_q, front_fill_d;
  logic [CNT_W-1:0]         back_fill_q, back_fill_d;
  logic [CNT_W-1:0]         slot_count_q, slot_count_d;
  logic                     done_q, done_d;
  rsp_t                     rsp_q, rsp_d;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic signed [KEY_W-1:0]  ram_wdata, ram_rdata;

  logic                     accept;
  logic [CNT_W-1:0]         active;
  logic [ADDR_W-1:0]        top;
  logic                     full;
  logic [ADDR_W-1:0]        back_start;
  logic                     region_empty;
  logic [ADDR_W-1:0]        start_pos;
  logic [ADDR_W-1:0]        nbr, nbr2;
  logic                     nbr_at_limit;
  logic                     cont;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    if (slot_count_q == '0) begin
      active = CNT_W'(1);
    end else if (slot_count_q > CNT_W'(DEPTH)) begin
      active = CNT_W'(DEPTH);
    end else begin
      active = slot_count_q;
    end
  end

  assign top  = ADDR_W'(active - CNT_W'(1));
  assign full = ({1'b0, front_fill_q} + {1'b0, back_fill_q}) >= {1'b0, active};
  // free slot guaranteed when not full, so this stays in range
  assign back_start   = top - back_fill_q[ADDR_W-1:0];
  assign region_empty = req_i.group ? (back_fill_q == '0) : (front_fill_q == '0);
  assign start_pos    = req_i.group ? back_start : front_fill_q[ADDR_W-1:0];

  // front walks down toward slot 0, back walks up toward the top slot
  assign nbr          = grp_q ? pos_q + ADDR_W'(1) : pos_q - ADDR_W'(1);
  assign nbr2         = grp_q ? pos_q + ADDR_W'(2) : pos_q - ADDR_W'(2);
  assign nbr_at_limit = grp_q ? (nbr == top) : (nbr == '0);
  // neighbor moves over when it must sit on the far side of the new key
  assign cont         = grp_q ? (key_q < ram_rdata) : (ram_rdata < key_q);

  // next state and datapath registers
  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    grp_d        = grp_q;
    key_d        = key_q;
    front_fill_d = front_fill_q;
    back_fill_d  = back_fill_q;
    slot_count_d = slot_count_q;
    done_d       = 1'b0;
    rsp_d        = rsp_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rsp_d.read_key = '0;
          rsp_d.status   = ST_OK;
          case (req_i.mode)
            MODE_INSERT: begin
              if (full) begin
                done_d       = 1'b1;
                rsp_d.status = ST_FULL;
              end else begin
                grp_d   = req_i.group;
                key_d   = req_i.key;
                pos_d   = start_pos;
                state_d = region_empty ? S_PLACE : S_SHIFT;
              end
            end
            MODE_READ: begin
              if ({1'b0, req_i.index} >= active) begin
                done_d       = 1'b1;
                rsp_d.status = ST_RANGE;
              end else begin
                state_d = S_READ;
              end
            end
            MODE_CLEAR: begin
              front_fill_d = '0;
              back_fill_d  = '0;
              done_d       = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (cont) begin
          pos_d   = nbr;
          state_d = nbr_at_limit ? S_PLACE : S_SHIFT;
        end else begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      S_PLACE: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
      end
      S_READ: begin
        state_d        = S_IDLE;
        done_d         = 1'b1;
        rsp_d.read_key = ram_rdata;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // insert completes: count the new entry
    if (done_d && (state_q == S_SHIFT || state_q == S_PLACE)) begin
      if (grp_q) begin
        back_fill_d = back_fill_q + CNT_W'(1);
      end else begin
        front_fill_d = front_fill_q + CNT_W'(1);
      end
    end

    if (cfg_we_i) begin
      slot_count_d = cfg_wdata_i;
      front_fill_d = '0;
      back_fill_d  = '0;
    end

    rsp_d.front_count = front_fill_d;
    rsp_d.back_count  = back_fill_d;
  end

  // RAM control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = key_q;
    ram_raddr = nbr2;

    case (state_q)
      S_IDLE: begin
        if (req_i.mode == MODE_READ) begin
          ram_raddr = req_i.index;
        end else begin
          ram_raddr = req_i.group ? start_pos + ADDR_W'(1) : start_pos - ADDR_W'(1);
        end
      end
      S_SHIFT: begin
        ram_we = 1'b1;
        if (cont) begin
          ram_wdata = ram_rdata;
        end
      end
      S_PLACE: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  trsi_ram #(
    .Depth(DEPTH),
    .Width(KEY_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      front_fill_q <= '0;
      back_fill_q  <= '0;
      slot_count_q <= CNT_W'(DEPTH);
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      front_fill_q <= front_fill_d;
      back_fill_q  <= back_fill_d;
      slot_count_q <= slot_count_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    grp_q <= grp_d;
    key_q <= key_d;
    rsp_q <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // fills never exceed the slots in use
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, front_fill_q} + {1'b0, back_fill_q}) <= {1'b0, active})
    else $error("fill counts exceed active slots");

  // a read item answers right after its RAM read
  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> done_o)
    else $error("read result missing");

  // the walk stays inside the slots in use
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT || state_q == S_PLACE) |-> (pos_q <= top))
    else $error("insert position out of range");

  // overlapped read never targets the entry being written
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && cont && !nbr_at_limit) |-> (ram_raddr != ram_waddr))
    else $error("read and write to same slot");

endmodule

// File: sv/trsi_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module trsi_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: sim/tb_two_region_sorted_insert.sv
// Self-checking testbench for two_region_sorted_insert: queued items, clocked driver and
// monitor, and a predictor of both sorted regions. Depends on trsi_pkg and the block's RTL.
module tb_two_region_sorted_insert;
  timeunit 1ns;
  timeprecision 1ps;
  import trsi_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned SETTLE_CYC  = 4;
  localparam int unsigned PHASE_ITEMS = 175;
  localparam logic [1:0]  MODE_SPARE  = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic             is_cfg;
    logic [CNT_W-1:0] slots;
    req_t             req;
  } op_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  req_t             req_i;
  logic             busy_o;
  logic             done_o;
  rsp_t             rsp_o;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  op_t  pending_ops[$];
  rsp_t awaited_rsp[$];
  logic took;
  int   err_count;
  int   cycles;
  int   issued;
  int   settle_left;

  // predictor state
  logic signed [KEY_W-1:0] shadow_keys[DEPTH];
  int                      front_n;
  int                      back_n;
  logic [CNT_W-1:0]        slots_cfg;

  two_region_sorted_insert u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic int live_slots(logic [CNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > DEPTH) return DEPTH;
    return int'(v);
  endfunction

  function automatic void set_slot_count(logic [CNT_W-1:0] v);
    slots_cfg = v;
    front_n   = 0;
    back_n    = 0;
  endfunction

  function automatic rsp_t sorted_insert_step(req_t r);
    rsp_t res;
    int   top, m, j, i;
    logic hit;
    res = '0;
    if (r.mode == MODE_INSERT) begin
      if (front_n + back_n >= live_slots(slots_cfg)) begin
        res.status = ST_FULL;
      end else if (r.group == 1'b0) begin
        // skip over keys >= new key so equal keys keep arrival order
        j = 0;
        while (j < front_n && !(shadow_keys[j] < r.key)) j++;
        for (i = front_n; i > j; i--) shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[j] = r.key;
        front_n++;
      end else begin
        top = live_slots(slots_cfg) - 1;
        m   = top - back_n;
        j   = top;
        hit = 1'b0;
        while (j > m && !hit) begin
          if (r.key < shadow_keys[j]) hit = 1'b1;
          else j--;
        end
        if (!hit) j = m;
        for (i = m; i < j; i++) shadow_keys[i] = shadow_keys[i+1];
        shadow_keys[j] = r.key;
        back_n++;
      end
    end else if (r.mode == MODE_READ) begin
      if (int'(r.index) >= live_slots(slots_cfg)) res.status = ST_RANGE;
      else res.read_key = shadow_keys[r.index];
    end else if (r.mode == MODE_CLEAR) begin
      front_n = 0;
      back_n  = 0;
    end
    res.front_count = CNT_W'(front_n);
    res.back_count  = CNT_W'(back_n);
    return res;
  endfunction

  function automatic logic signed [KEY_W-1:0] draw_key();
    case ($urandom_range(9))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2, 3:    return KEY_W'(int'($urandom_range(6)) - 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_item(logic [1:0] mode, logic grp,
                                    logic signed [KEY_W-1:0] key, int idx);
    op_t op;
    op           = '0;
    op.req.mode  = mode;
    op.req.group = grp;
    op.req.key   = key;
    op.req.index = ADDR_W'(idx);
    pending_ops.push_back(op);
  endfunction

  function automatic void push_slot_count(logic [CNT_W-1:0] v);
    op_t op;
    op        = '0;
    op.is_cfg = 1'b1;
    op.slots  = v;
    pending_ops.push_back(op);
  endfunction

  function automatic void push_random_item(int lim);
    int sel;
    int idx;
    sel = $urandom_range(99);
    idx = ($urandom_range(3) == 0) ? $urandom_range(DEPTH-1) : $urandom_range(lim-1);
    if (sel < 60)
      push_item(MODE_INSERT, 1'($urandom_range(1)), draw_key(), $urandom_range(DEPTH-1));
    else if (sel < 97)
      push_item(MODE_READ, 1'($urandom_range(1)), $urandom, idx);
    else if (sel < 99)
      push_item(MODE_CLEAR, 1'($urandom_range(1)), $urandom, idx);
    else
      push_item(MODE_SPARE, 1'($urandom_range(1)), $urandom, idx);
  endfunction

  // driver: at most one item or register write per falling edge; an item is held until taken
  always @(negedge clk_i) begin
    op_t  op;
    logic start_n;
    logic cfg_n;
    start_n = 1'b0;
    cfg_n   = 1'b0;
    if (rst_ni) begin
      if (start_i && !took) begin
        start_n = 1'b1;
      end else if (pending_ops.size() != 0) begin
        if (pending_ops[0].is_cfg) begin
          // register writes only once the block has answered everything
          if (awaited_rsp.size() == 0 && !busy_o && !start_i) begin
            if (settle_left > 0) begin
              settle_left--;
            end else begin
              op = pending_ops.pop_front();
              cfg_wdata_i <= op.slots;
              cfg_n       = 1'b1;
              settle_left = SETTLE_CYC;
            end
          end else begin
            settle_left = SETTLE_CYC;
          end
        end else if ((issued >= 600 && issued < 900) || $urandom_range(99) >= 8) begin
          op = pending_ops.pop_front();
          req_i <= op.req;
          start_n = 1'b1;
          issued++;
        end
      end
    end
    start_i  <= start_n;
    cfg_we_i <= cfg_n;
  end

  // monitor: check results, then predict for the item taken at this edge
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (awaited_rsp.size() == 0) begin
          $error("result with none expected: read_key %0d", rsp_o.read_key);
          err_count++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_o.read_key !== want.read_key) begin
            $error("read_key: expected %0d, got %0d", want.read_key, rsp_o.read_key);
            err_count++;
          end
          if (rsp_o.front_count !== want.front_count) begin
            $error("front_count: expected %0d, got %0d", want.front_count, rsp_o.front_count);
            err_count++;
          end
          if (rsp_o.back_count !== want.back_count) begin
            $error("back_count: expected %0d, got %0d", want.back_count, rsp_o.back_count);
            err_count++;
          end
          if (rsp_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_o.status);
            err_count++;
          end
        end
      end
      if (cfg_we_i) set_slot_count(cfg_wdata_i);
      if (start_i && !busy_o) awaited_rsp.push_back(sorted_insert_step(req_i));
      took <= start_i && !busy_o;
    end else begin
      took <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [CNT_W-1:0] phase_slots[8];
    int               lim;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    took        = 1'b0;
    err_count   = 0;
    cycles      = 0;
    issued      = 0;
    settle_left = SETTLE_CYC;
    for (int i = 0; i < DEPTH; i++) shadow_keys[i] = '0;
    front_n   = 0;
    back_n    = 0;
    slots_cfg = CNT_W'(DEPTH);

    // fill the whole store first so every slot holds a written key
    for (int i = 0; i < DEPTH; i++)
      push_item(MODE_INSERT, 1'($urandom_range(1)), draw_key(), $urandom_range(DEPTH-1));

    // store full, reads at both ends, spare mode, clear
    push_item(MODE_INSERT, 1'b0, '0, 0);
    push_item(MODE_INSERT, 1'b1, KEY_MAX, 0);
    push_item(MODE_READ, 1'b0, '0, 0);
    push_item(MODE_READ, 1'b1, '0, DEPTH-1);
    push_item(MODE_SPARE, 1'b1, '1, DEPTH-1);
    push_item(MODE_CLEAR, 1'b0, '0, 0);
    // key extremes, equal keys, and the back region's second entry
    push_item(MODE_INSERT, 1'b0, KEY_MIN, 0);
    push_item(MODE_INSERT, 1'b0, KEY_MAX, 0);
    push_item(MODE_INSERT, 1'b0, 32'sd5, 0);
    push_item(MODE_INSERT, 1'b0, 32'sd5, 0);
    push_item(MODE_INSERT, 1'b1, 32'sd7, 0);
    push_item(MODE_INSERT, 1'b1, -32'sd1, 0);
    push_item(MODE_INSERT, 1'b1, 32'sd7, 0);
    push_item(MODE_INSERT, 1'b1, KEY_MAX, 0);
    push_item(MODE_INSERT, 1'b1, KEY_MIN, 0);
    push_item(MODE_READ, 1'b0, '0, 0);
    push_item(MODE_READ, 1'b0, '0, 2);
    push_item(MODE_READ, 1'b0, '0, DEPTH-1);
    push_item(MODE_READ, 1'b0, '0, DEPTH-3);
    push_item(MODE_READ, 1'b0, '0, DEPTH-5);
    // zero slots acts as one
    push_slot_count('0);
    push_item(MODE_READ, 1'b0, '0, 1);
    push_item(MODE_READ, 1'b0, '0, 0);
    push_item(MODE_INSERT, 1'b1, 32'sd3, 0);
    push_item(MODE_INSERT, 1'b0, 32'sd4, 0);
    // above the store size acts as the full size
    push_slot_count('1);
    push_item(MODE_READ, 1'b0, '0, DEPTH-1);

    phase_slots = '{7'd1, 7'd127, 7'd2, 7'd65, CNT_W'($urandom_range(3, 63)),
                    7'd64, 7'd0, CNT_W'($urandom_range(3, 20))};
    for (int p = 0; p < 8; p++) begin
      push_slot_count(phase_slots[p]);
      lim = live_slots(phase_slots[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) push_random_item(lim);
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_ops.size() != 0 || start_i || cfg_we_i) @(posedge clk_i);
    while (awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/trsi_pkg.sv
sv/trsi_ram.sv
sv/two_region_sorted_insert.sv
sim/tb_two_region_sorted_insert.sv
